@@ rtl/core/gclw_pkg.sv @@
// Shared types and constants for the grid cell line walker.
package gclw_pkg;

    localparam int CELL_W = 13;
    localparam int DIFF_W = 14;

    typedef logic signed [CELL_W-1:0] cell_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic [CELL_W-1:0]        dist_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVX,
        ST_DIVY,
        ST_SETUP,
        ST_WALK,
        ST_PTR,
        ST_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_CELL_SIZE   = 3'd2,
        REG_GRID_WIDTH  = 3'd3,
        REG_GRID_HEIGHT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/core/gclw_div.sv @@
// Bit-serial signed divider that maps a pixel offset to a cell index.
module gclw_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  gclw_pkg::cell_t   dividend,
    input  logic [7:0]        divisor,
    output gclw_pkg::div_stat_t stat,
    output gclw_pkg::cell_t   quotient
);
    import gclw_pkg::*;

    localparam int CNT_W = $clog2(CELL_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CELL_W-1:0] mag_reg, mag_next;
    logic [7:0]        rem_reg, rem_next;
    logic [7:0]        dsr_reg, dsr_next;
    logic              neg_reg, neg_next;
    logic [8:0]        trial;
    logic [8:0]        trial_sub;
    logic              ge;

    always_comb begin
        trial     = {rem_reg, mag_reg[CELL_W-1]};
        trial_sub = trial - {1'b0, dsr_reg};
        ge        = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start) begin
            // Work on the magnitude and fix the sign at the end: truncation toward zero.
            neg_next  = dividend[CELL_W-1];
            mag_next  = dividend[CELL_W-1] ? CELL_W'(-dividend) : CELL_W'(dividend);
            dsr_next  = (divisor == 8'd0) ? 8'd1 : divisor;
            rem_next  = 8'd0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? trial_sub[7:0] : trial[7:0];
            mag_next = {mag_reg[CELL_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CELL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? cell_t'(-mag_reg) : cell_t'(mag_reg);

endmodule

@@ rtl/core/grid_cell_line_walker_unit.sv @@
// Grid cell line walker: maps each pointer sample to a grid cell and emits the trail of
// cells from the previous sample's cell to the current one, then the current cell itself.
// The two cell divisions share one bit-serial divider (13 steps each), and the trail walker
// visits one cell per cycle while the result channel does not stall, with a remainder
// accumulator per axis, over a distance N, the larger of the column and row distances
// between the previous and the current cell. Only cells inside the grid are emitted, at most
// GRID_MAX trail cells per sample; the final result of each sample carries tlast, and tuser
// marks the current pointer cell.
module grid_cell_line_walker_unit #(
    parameter int GRID_MAX = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input transaction.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] pointer_x, [23:12] pointer_y
    // Result transaction.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] cell_x, [11:6] cell_y, [15:12] zero
    output logic        m_tuser,   // kind
    output logic        m_tlast,   // last
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gclw_pkg::*;

    localparam int CNT_W = $clog2(GRID_MAX + 1);

    function automatic logic in_grid(input diff_t t, input logic [5:0] lim);
        in_grid = !t[DIFF_W-1] && (t[DIFF_W-2:0] < {{(DIFF_W-7){1'b0}}, lim});
    endfunction

    // Configuration registers.
    logic signed [11:0] org_x_reg, org_y_reg;
    logic [7:0]         cell_size_reg;
    logic [5:0]         grid_w_reg, grid_h_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    // Sequencer and datapath.
    state_t            state_reg, state_next;
    logic signed [11:0] py_reg;
    cell_t             cx_reg, cy_reg;
    cell_t             prev_x_reg, prev_y_reg;
    logic              prev_valid_reg;
    diff_t             jx_reg, jy_reg;
    dist_t             n_total_reg, n_reg;
    diff_t             qx_reg, qy_reg, qx_next, qy_next;
    dist_t             rx_reg, ry_reg, rx_next, ry_next;
    logic [CNT_W-1:0]  trail_cnt_reg;

    logic              pend_valid_reg;
    logic [5:0]        pend_x_reg, pend_y_reg;
    logic              pend_kind_reg;

    logic              m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [5:0]        m_x_reg, m_y_reg;

    // Divider hookup.
    logic              div_start;
    cell_t             div_dividend;
    div_stat_t         div_stat;
    cell_t             div_quot;

    // Setup arithmetic.
    cell_t             ox, oy;
    diff_t             jx, jy, ax, ay;
    dist_t             n_total;

    // Walk arithmetic.
    diff_t             tx, ty;
    logic signed [15:0] rx_dec, ry_dec, n_ext;

    // Control strobes.
    logic              out_free;
    logic              hit;
    logic              go;
    logic              load_pend;
    logic              push_mid;
    logic              push_last;
    logic [5:0]        new_x, new_y;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_comb begin
        case (cfg_idx)
            REG_ORIGIN_X:    prdata = {20'd0, org_x_reg};
            REG_ORIGIN_Y:    prdata = {20'd0, org_y_reg};
            REG_CELL_SIZE:   prdata = {24'd0, cell_size_reg};
            REG_GRID_WIDTH:  prdata = {26'd0, grid_w_reg};
            REG_GRID_HEIGHT: prdata = {26'd0, grid_h_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg     <= 12'sd0;
            org_y_reg     <= 12'sd0;
            cell_size_reg <= 8'd16;
            grid_w_reg    <= 6'd32;
            grid_h_reg    <= 6'd32;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ORIGIN_X:    org_x_reg     <= pwdata[11:0];
                REG_ORIGIN_Y:    org_y_reg     <= pwdata[11:0];
                REG_CELL_SIZE:   cell_size_reg <= pwdata[7:0];
                REG_GRID_WIDTH:  grid_w_reg    <= pwdata[5:0];
                REG_GRID_HEIGHT: grid_h_reg    <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // X offset comes straight from the accepted transaction, Y from the held sample.
    always_comb begin
        if (state_reg == ST_IDLE) begin
            div_dividend = cell_t'({s_tdata[11], s_tdata[11:0]})
                         - cell_t'({org_x_reg[11], org_x_reg});
        end else begin
            div_dividend = cell_t'({py_reg[11], py_reg}) - cell_t'({org_y_reg[11], org_y_reg});
        end
        div_start = (s_tvalid && s_tready) || (state_reg == ST_DIVX && div_stat.done);
    end

    gclw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cell_size_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Setup: distance to the previous cell.
    always_comb begin
        ox = prev_valid_reg ? prev_x_reg : cx_reg;
        oy = prev_valid_reg ? prev_y_reg : cy_reg;
        jx = diff_t'(ox) - diff_t'(cx_reg);
        jy = diff_t'(oy) - diff_t'(cy_reg);
        ax = jx[DIFF_W-1] ? -jx : jx;
        ay = jy[DIFF_W-1] ? -jy : jy;
        n_total = (ax > ay) ? ax[CELL_W-1:0] : ay[CELL_W-1:0];
    end

    // Walk: Q and R hold floor((c*N + j*n) / N) and its remainder; stepping n down
    // subtracts j from R, which moves Q by at most one since |j| <= N.
    always_comb begin
        tx = (qx_reg[DIFF_W-1] && rx_reg != '0) ? qx_reg + diff_t'(1) : qx_reg;
        ty = (qy_reg[DIFF_W-1] && ry_reg != '0) ? qy_reg + diff_t'(1) : qy_reg;
        n_ext  = $signed({3'b000, n_total_reg});
        rx_dec = $signed({3'b000, rx_reg}) - $signed({{2{jx_reg[DIFF_W-1]}}, jx_reg});
        ry_dec = $signed({3'b000, ry_reg}) - $signed({{2{jy_reg[DIFF_W-1]}}, jy_reg});
        qx_next = qx_reg;
        qy_next = qy_reg;
        rx_next = rx_dec[CELL_W-1:0];
        ry_next = ry_dec[CELL_W-1:0];
        if (rx_dec[15]) begin
            rx_next = 13'(rx_dec + n_ext);
            qx_next = qx_reg - diff_t'(1);
        end else if (rx_dec >= n_ext) begin
            rx_next = 13'(rx_dec - n_ext);
            qx_next = qx_reg + diff_t'(1);
        end
        if (ry_dec[15]) begin
            ry_next = 13'(ry_dec + n_ext);
            qy_next = qy_reg - diff_t'(1);
        end else if (ry_dec >= n_ext) begin
            ry_next = 13'(ry_dec - n_ext);
            qy_next = qy_reg + diff_t'(1);
        end
    end

    // Control strobes. A result waits in the pending register until the next one is
    // found or the sample ends, so that tlast can be set on the final one.
    always_comb begin
        out_free  = !m_tvalid_reg || m_tready;
        hit       = 1'b0;
        new_x     = tx[5:0];
        new_y     = ty[5:0];
        case (state_reg)
            ST_WALK: begin
                hit = (trail_cnt_reg < CNT_W'(GRID_MAX)) && in_grid(tx, grid_w_reg)
                      && in_grid(ty, grid_h_reg);
            end
            ST_PTR: begin
                hit   = in_grid(diff_t'(cx_reg), grid_w_reg) && in_grid(diff_t'(cy_reg), grid_h_reg);
                new_x = cx_reg[5:0];
                new_y = cy_reg[5:0];
            end
            default: hit = 1'b0;
        endcase
        go        = !hit || !pend_valid_reg || out_free;
        load_pend = (state_reg == ST_WALK || state_reg == ST_PTR) && hit && go;
        push_mid  = load_pend && pend_valid_reg;
        push_last = (state_reg == ST_FLUSH) && pend_valid_reg && out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_DIVX;
            ST_DIVX:  if (div_stat.done) state_next = ST_DIVY;
            ST_DIVY:  if (div_stat.done) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_WALK;
            ST_WALK:  if (go && n_reg == '0) state_next = ST_PTR;
            ST_PTR:   if (go) state_next = ST_FLUSH;
            ST_FLUSH: if (!pend_valid_reg || out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_valid_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SETUP) begin
                prev_x_reg     <= cx_reg;
                prev_y_reg     <= cy_reg;
                prev_valid_reg <= 1'b1;
            end
            if (load_pend) begin
                pend_valid_reg <= 1'b1;
            end else if (push_last) begin
                pend_valid_reg <= 1'b0;
            end
            if (push_mid || push_last) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            py_reg <= s_tdata[23:12];
        end
        if (state_reg == ST_DIVX && div_stat.done) begin
            cx_reg <= div_quot;
        end
        if (state_reg == ST_DIVY && div_stat.done) begin
            cy_reg <= div_quot;
        end
        if (state_reg == ST_SETUP) begin
            jx_reg        <= jx;
            jy_reg        <= jy;
            n_total_reg   <= n_total;
            n_reg         <= n_total;
            qx_reg        <= diff_t'(ox);
            qy_reg        <= diff_t'(oy);
            rx_reg        <= '0;
            ry_reg        <= '0;
            trail_cnt_reg <= '0;
        end else if (state_reg == ST_WALK && go) begin
            n_reg  <= n_reg - 1'b1;
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            if (load_pend) begin
                trail_cnt_reg <= trail_cnt_reg + 1'b1;
            end
        end
        if (load_pend) begin
            pend_x_reg    <= new_x;
            pend_y_reg    <= new_y;
            pend_kind_reg <= (state_reg == ST_PTR);
        end
        if (push_mid || push_last) begin
            m_x_reg     <= pend_x_reg;
            m_y_reg     <= pend_y_reg;
            m_tuser_reg <= pend_kind_reg;
            m_tlast_reg <= push_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_y_reg, m_x_reg};
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_trail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (trail_cnt_reg <= CNT_W'(GRID_MAX)))
        else $error("trail count beyond its limit");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && n_total_reg != '0) |->
        (rx_reg < n_total_reg && ry_reg < n_total_reg))
        else $error("walk remainder out of range");

    a_pend_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left behind at end of sample");

    a_out_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] < grid_w_reg && m_tdata[11:6] < grid_h_reg))
        else $error("emitted cell outside the grid");
`endif

endmodule

@@ test/gclw_checker.sv @@
// Result checker for the grid cell line walker: tracks the registers, predicts cells, compares.
`timescale 1ns / 100ps
module gclw_checker #(
    parameter int GRID_MAX = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [11:0] pointer_x, [23:12] pointer_y
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // [5:0] cell_x, [11:6] cell_y, [15:12] zero
    input  logic        m_tuser,    // kind
    input  logic        m_tlast,    // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          cells_checked,
    output int          outstanding,
    output int          walk_span
);
    import gclw_pkg::*;

    typedef struct packed {
        logic [5:0] col;
        logic [5:0] row;
        logic       pointer_cell;
        logic       final_cell;
    } grid_cell_t;

    int org_x = 0;
    int org_y = 0;
    int cell_side = 16;
    int cols = 32;
    int rows = 32;

    int last_col = 0;
    int last_row = 0;
    bit have_last = 1'b0;
    int span_seen = 0;

    int fail_count = 0;
    int match_count = 0;
    grid_cell_t expected_cells[$];

    function automatic bit inside_grid(input longint x, input longint y);
        return x >= 0 && x < cols && y >= 0 && y < rows;
    endfunction

    function automatic grid_cell_t mark(input longint x, input longint y, input logic ptr);
        grid_cell_t c;
        c.col          = 6'(x);
        c.row          = 6'(y);
        c.pointer_cell = ptr;
        c.final_cell   = 1'b0;
        return c;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Walks n from the full distance down to zero; each visit lands on
    // trunc((cur*N + (prev-cur)*n) / N), which is exact in integers.
    task automatic predict_cells(input logic [11:0] raw_x, input logic [11:0] raw_y);
        int side, cur_col, cur_row, from_col, from_row, dcol, drow, span, n, trail;
        longint tx, ty;
        grid_cell_t found[$];
        side = (cell_side == 0) ? 1 : cell_side;
        cur_col = (int'($signed(raw_x)) - org_x) / side;
        cur_row = (int'($signed(raw_y)) - org_y) / side;
        from_col = have_last ? last_col : cur_col;
        from_row = have_last ? last_row : cur_row;
        dcol = from_col - cur_col;
        drow = from_row - cur_row;
        span = (dcol < 0) ? -dcol : dcol;
        if (((drow < 0) ? -drow : drow) > span) begin
            span = (drow < 0) ? -drow : drow;
        end
        trail = 0;
        if (span == 0) begin
            if (inside_grid(cur_col, cur_row)) begin
                found = {found, mark(cur_col, cur_row, 1'b0)};
            end
        end else begin
            for (n = span; n >= 0; n--) begin
                tx = (longint'(cur_col) * span + longint'(dcol) * n) / span;
                ty = (longint'(cur_row) * span + longint'(drow) * n) / span;
                if (trail < GRID_MAX && inside_grid(tx, ty)) begin
                    found = {found, mark(tx, ty, 1'b0)};
                    trail++;
                end
            end
        end
        if (inside_grid(cur_col, cur_row)) begin
            found = {found, mark(cur_col, cur_row, 1'b1)};
        end
        if (found.size() > 0) begin
            found[found.size()-1].final_cell = 1'b1;
        end
        expected_cells = {expected_cells, found};
        last_col  = cur_col;
        last_row  = cur_row;
        have_last = 1'b1;
        span_seen = span;
    endtask

    always @(posedge aclk) begin
        grid_cell_t want;
        if (!aresetn) begin
            org_x     = 0;
            org_y     = 0;
            cell_side = 16;
            cols      = 32;
            rows      = 32;
            last_col  = 0;
            last_row  = 0;
            have_last = 1'b0;
            span_seen = 0;
            expected_cells.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_ORIGIN_X:    org_x = int'($signed(pwdata[11:0]));
                    REG_ORIGIN_Y:    org_y = int'($signed(pwdata[11:0]));
                    REG_CELL_SIZE:   cell_side = int'(pwdata[7:0]);
                    REG_GRID_WIDTH:  cols = int'(pwdata[5:0]);
                    REG_GRID_HEIGHT: rows = int'(pwdata[5:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_cells.size() == 0) begin
                    fail_count++;
                    $display("%0t: result transaction with none expected, actual x=%0d y=%0d kind=%0d last=%0d",
                             $time, m_tdata[5:0], m_tdata[11:6], m_tuser, m_tlast);
                end else begin
                    want = expected_cells.pop_front();
                    match_count++;
                    check_field("cell_x", want.col, m_tdata[5:0]);
                    check_field("cell_y", want.row, m_tdata[11:6]);
                    check_field("tdata padding", 0, m_tdata[15:12]);
                    check_field("kind", want.pointer_cell, m_tuser);
                    check_field("last", want.final_cell, m_tlast);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_cells(s_tdata[11:0], s_tdata[23:12]);
            end
        end
        mismatches    <= fail_count;
        cells_checked <= match_count;
        outstanding   <= expected_cells.size();
        walk_span     <= span_seen;
    end

endmodule

@@ test/tb_top.sv @@
// Top-level testbench for the grid cell line walker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
    import gclw_pkg::*;

    localparam int GRID_MAX = 32;
    localparam int QUIET_LIMIT = 50000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [11:0] pointer_x, [23:12] pointer_y
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [5:0] cell_x, [11:6] cell_y, [15:12] zero
    logic        m_tuser;    // kind
    logic        m_tlast;    // last
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int cells_checked;
    int outstanding;
    int walk_span;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int samples_sent = 0;
    int settings_used = 1;
    int cfg_org_x = 0;
    int cfg_org_y = 0;
    int cfg_side = 16;
    int cfg_cols = 32;
    int cfg_rows = 32;
    int pos_x = 0;
    int pos_y = 0;

    grid_cell_line_walker_unit #(.GRID_MAX(GRID_MAX)) DUT (.*);

    gclw_checker #(.GRID_MAX(GRID_MAX)) cell_check (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("grid_cell_line_walker_unit verification failed");
            $finish;
        end
    end

    function automatic int clamp_pos(input int v);
        return (v < -2048) ? -2048 : ((v > 2047) ? 2047 : v);
    endfunction

    // Leaves psel and penable high; the caller drops them after the last write.
    task automatic write_reg(input reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic send_pointer(input int x, input int y);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y[11:0], x[11:0]};
        pos_x = x;
        pos_y = y;
        samples_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds the input side until every predicted cell has come, then lets
    // a trail that emits nothing run out before anything else happens.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (40 + walk_span) @(posedge aclk);
    endtask

    task automatic program_grid(input int ox, input int oy, input int side,
                                input int ncols, input int nrows);
        settle_block();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_CELL_SIZE, side);
        write_reg(REG_GRID_WIDTH, ncols);
        write_reg(REG_GRID_HEIGHT, nrows);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_org_x = ox;
        cfg_org_y = oy;
        cfg_side  = side;
        cfg_cols  = ncols;
        cfg_rows  = nrows;
        settings_used++;
    endtask

    // Random moves around the grid, with some jitter of up to three cells from the last
    // pointer, some jumps anywhere in the coordinate range and some repeats in place.
    task automatic wander(input int count);
        int side, lo_x, hi_x, lo_y, hi_y, pick, nx, ny;
        side = (cfg_side == 0) ? 1 : cfg_side;
        lo_x = clamp_pos(cfg_org_x - 2 * side);
        hi_x = clamp_pos(cfg_org_x + (cfg_cols + 2) * side);
        lo_y = clamp_pos(cfg_org_y - 2 * side);
        hi_y = clamp_pos(cfg_org_y + (cfg_rows + 2) * side);
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                nx = lo_x + int'($urandom_range(hi_x - lo_x));
                ny = lo_y + int'($urandom_range(hi_y - lo_y));
            end else if (pick < 75) begin
                nx = clamp_pos(pos_x + int'($urandom_range(6 * side)) - 3 * side);
                ny = clamp_pos(pos_y + int'($urandom_range(6 * side)) - 3 * side);
            end else if (pick < 90) begin
                nx = int'($signed(12'($urandom)));
                ny = int'($signed(12'($urandom)));
            end else begin
                nx = pos_x;
                ny = pos_y;
            end
            send_pointer(nx, ny);
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: origin 0, 16-pixel cells, 32 by 32 grid.
        send_pointer(100, 100);      // first sample has no previous cell
        send_pointer(103, 110);      // same cell again
        send_pointer(300, 200);
        send_pointer(-15, -15);      // negative offset still truncates to cell 0
        send_pointer(-16, -40);
        send_pointer(511, 511);      // far corner of the grid
        send_pointer(512, 0);        // just past the right edge
        send_pointer(0, 0);
        send_pointer(511, 0);        // full-length row: trail limit plus pointer cell
        send_pointer(2047, 2047);
        send_pointer(-2048, -2048);
        send_pointer(2047, -2048);
        send_pointer(-2048, 2047);
        send_pointer(-1, -1);
        send_pointer(1365, -1366);
        send_pointer(-1366, 1365);
        wander(10);

        program_grid(-2048, -2048, 255, 63, 63);
        send_idle_pct = 65;
        send_pointer(-2048, -2048);
        send_pointer(2047, 2047);
        wander(15);

        program_grid(100, -50, 3, 63, 63);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        send_pointer(100, -50);
        send_pointer(286, 70);       // long diagonal: more in-grid visits than kept
        send_pointer(100, -50);
        settle_block();
        wander(25);

        program_grid(2047, 2047, 1, 1, 1);
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        send_pointer(2047, 2047);
        send_pointer(-2048, -2048);
        send_pointer(2047, 2047);
        wander(10);

        program_grid(0, 0, 0, 0, 63);    // zero cell size, zero width
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wander(6);

        program_grid(0, 0, 255, 63, 0);  // zero height
        wander(5);

        program_grid(-5, -5, 0, 10, 10);
        recv_stall_pct = 65;
        wander(15);

        program_grid(-37, 21, 16, 32, 32);
        send_idle_pct  = 65;
        recv_stall_pct = 0;
        wander(20);

        settle_block();
        $display("Sent %0d pointer samples across %0d grid settings and checked %0d result cells.",
                 samples_sent, settings_used, cells_checked);
        if (outstanding != 0) begin
            $display("%0t: %0d expected result cells never arrived", $time, outstanding);
        end
        if (mismatches == 0 && outstanding == 0) begin
            $display("grid_cell_line_walker_unit verification clean");
        end else begin
            $display("grid_cell_line_walker_unit verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/gclw_pkg.sv
rtl/core/gclw_div.sv
rtl/core/grid_cell_line_walker_unit.sv
test/gclw_checker.sv
test/tb_top.sv
